// ===== rtl/rst_polynomial_controller_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef RST_POLYNOMIAL_CONTROLLER_MACROS_SVH
`define RST_POLYNOMIAL_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define RPC_ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("rpc assertion failed");
`define RPC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rpc assertion failed");
`else
`define RPC_ASSERT_CLK(label, clk, prop)
`define RPC_ASSERT(label, clk, rst_n, prop)
`endif
`endif

// ===== rtl/rpc_pkg.sv =====
`default_nettype none

package rpc_pkg;

  localparam int MEAS_W     = 16;
  localparam int CMD_W      = 32;
  localparam int CMD_FRAC_W = 16;
  localparam int ACC_W      = 64;
  localparam int OFS_W      = 48;
  localparam int OPND_W     = MEAS_W + CMD_FRAC_W + 1;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int TERM_W     = 5;
  localparam int TAB_LEN    = 9;

  localparam int DEC_SCALE  = 10000000;
  localparam int DEC_HALF   = DEC_SCALE / 2;

  // ceil(2^80 / DEC_SCALE), exact floor quotient for numerators below 2^56
  localparam int           RECIP_SHIFT = 80;
  localparam logic [127:0] DEC_RECIP   = ((128'd1 << RECIP_SHIFT) + 128'(DEC_SCALE) - 128'd1)
                                         / 128'(DEC_SCALE);

  // coefficients in units of 1e-7
  localparam int R_DEC [TAB_LEN] = '{-1026000, 3352000, -3854000, 1767000, -238000,
                                     0, 0, 0, 0};
  localparam int S_DEC [TAB_LEN] = '{10000000, -30838000, 33476000, -14389000, 1751000,
                                     0, 0, 0, 0};
  localparam int T_DEC [TAB_LEN] = '{8712, -15249, 8767, -1493, 0, 0, 0, 0, 0};

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [CMD_W-1:0] CMD_MAX = {1'b0, {(CMD_W-1){1'b1}}};
  localparam logic signed [CMD_W-1:0] CMD_MIN = {1'b1, {(CMD_W-1){1'b0}}};
  localparam logic signed [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
  localparam logic signed [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_MEASURE  = 2'd0,
    CFG_INIT_COMMAND  = 2'd1,
    CFG_INIT_SETPOINT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    COEF_R,
    COEF_S,
    COEF_T
  } coef_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              load;
    logic              load_reinit;
    logic              mul_en;
    logic              acc_en;
    logic              commit_sample;
    logic              commit_reinit;
    logic [TERM_W-1:0] term_idx;
  } dp_ctrl_t;

  typedef struct packed {
    logic out_full;
  } dp_stat_t;

  // round to nearest, ties away from zero
  // magnitudes stay below 2^25 and frac at most 30, so the numerator is below 2^56
  function automatic longint quantize(input int d, input int frac);
    longint unsigned mag;
    logic [127:0]    num;
    logic [127:0]    prod;
    longint unsigned q;
    mag  = (d < 0) ? longint'(-longint'(d)) : longint'(d);
    num  = {64'd0, mag} << frac;
    num  = num + 128'(DEC_HALF);
    prod = num * DEC_RECIP;
    q    = prod[RECIP_SHIFT +: 64];
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic int dec_of(input coef_kind_e kind, input int j);
    int v;
    unique case (kind)
      COEF_R:  v = R_DEC[j];
      COEF_S:  v = S_DEC[j];
      default: v = T_DEC[j];
    endcase
    return v;
  endfunction

  function automatic longint coef_sum(input coef_kind_e kind, input int deg, input int frac);
    longint s;
    s = 0;
    for (int j = 0; j <= deg; j++) begin
      s += quantize(dec_of(kind, j), frac);
    end
    return s;
  endfunction

  // term order: reference taps, measurement taps, command taps, current
  // measurement, current setpoint, then the two offset terms of a reinit
  function automatic longint term_coef(input int k, input int t_deg, input int r_deg,
                                       input int s_deg, input int frac);
    longint c;
    if (k < t_deg) begin
      c = quantize(T_DEC[k + 1], frac);
    end else if (k < t_deg + r_deg) begin
      c = -quantize(R_DEC[k - t_deg + 1], frac);
    end else if (k < t_deg + r_deg + s_deg) begin
      c = -quantize(S_DEC[k - t_deg - r_deg + 1], frac);
    end else if (k == t_deg + r_deg + s_deg) begin
      c = -quantize(R_DEC[0], frac);
    end else if (k == t_deg + r_deg + s_deg + 1) begin
      c = quantize(T_DEC[0], frac);
    end else if (k == t_deg + r_deg + s_deg + 2) begin
      c = coef_sum(COEF_R, r_deg, frac) - coef_sum(COEF_T, t_deg, frac);
    end else begin
      c = coef_sum(COEF_S, s_deg, frac);
    end
    return c;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rpc_if.sv =====
`default_nettype none

interface rpc_in_if import rpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [MEAS_W-1:0] setpoint;
  logic [MEAS_W-1:0] measure;

  modport source (output valid, output cmd, output setpoint, output measure, input ready);
  modport sink   (input valid, input cmd, input setpoint, input measure, output ready);
endinterface

interface rpc_out_if import rpc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] command;

  modport source (output valid, output command, input ready);
  modport sink   (input valid, input command, output ready);
endinterface

`default_nettype wire

// ===== rtl/rpc_ctrl.sv =====
`default_nettype none
`include "rst_polynomial_controller_macros.svh"

module rpc_ctrl import rpc_pkg::*; #(
  parameter int R_DEGREE = 4,
  parameter int S_DEGREE = 4,
  parameter int T_DEGREE = 3
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_cmd_i,
  output logic     in_ready_o,
  output dp_ctrl_t dp_ctrl_o,
  input  dp_stat_t dp_stat_i
);

  localparam int NUM_TERMS   = T_DEGREE + R_DEGREE + S_DEGREE + 2;
  localparam int NUM_ENTRIES = NUM_TERMS + 2;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);

  localparam logic [IDX_W-1:0] LAST_SAMPLE = IDX_W'(NUM_TERMS - 1);
  localparam logic [IDX_W-1:0] FIRST_INIT  = IDX_W'(NUM_TERMS);
  localparam logic [IDX_W-1:0] LAST_INIT   = IDX_W'(NUM_TERMS + 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             mode_q, mode_d;
  logic             prod_vld_q, prod_vld_d;
  logic [IDX_W-1:0] last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      mode_q     <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      mode_q     <= mode_d;
      prod_vld_q <= prod_vld_d;
    end
  end

  assign last_idx = mode_q ? LAST_INIT : LAST_SAMPLE;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    mode_d     = mode_q;
    prod_vld_d = (state_q == ST_MAC);
    in_ready_o = (state_q == ST_IDLE);

    dp_ctrl_o               = '0;
    dp_ctrl_o.term_idx      = TERM_W'(cnt_q);
    // product of the previous cycle goes into the accumulator
    dp_ctrl_o.acc_en        = prod_vld_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dp_ctrl_o.load        = 1'b1;
          dp_ctrl_o.load_reinit = in_cmd_i;
          mode_d                = in_cmd_i;
          cnt_d                 = in_cmd_i ? FIRST_INIT : '0;
          state_d               = ST_MAC;
        end
      end
      ST_MAC: begin
        dp_ctrl_o.mul_en = 1'b1;
        if (cnt_q == last_idx) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (mode_q) begin
          dp_ctrl_o.commit_reinit = 1'b1;
          state_d                 = ST_IDLE;
        end else if (!dp_stat_i.out_full) begin
          dp_ctrl_o.commit_sample = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
    endcase
  end

  `RPC_ASSERT(a_accept_starts_mac, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == ST_MAC))
  `RPC_ASSERT(a_reinit_terms, clk_i, rst_ni, (state_q == ST_MAC && mode_q) |-> (cnt_q == FIRST_INIT || cnt_q == LAST_INIT))
  `RPC_ASSERT(a_sample_terms, clk_i, rst_ni, (state_q == ST_MAC && !mode_q) |-> (cnt_q <= LAST_SAMPLE))
  `RPC_ASSERT(a_drain_accumulates, clk_i, rst_ni, (state_q == ST_DRAIN) |-> dp_ctrl_o.acc_en)

endmodule

`default_nettype wire

// ===== rtl/rpc_datapath.sv =====
`default_nettype none
`include "rst_polynomial_controller_macros.svh"

module rpc_datapath import rpc_pkg::*; #(
  parameter int R_DEGREE       = 4,
  parameter int S_DEGREE       = 4,
  parameter int T_DEGREE       = 3,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic [MEAS_W-1:0]       setpoint_i,
  input  logic [MEAS_W-1:0]       measure_i,
  input  dp_ctrl_t                ctrl_i,
  output dp_stat_t                stat_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [CMD_W-1:0] command_o
);

  localparam int COEF_W      = COEF_FRAC_BITS + 3;
  localparam int NUM_TERMS   = T_DEGREE + R_DEGREE + S_DEGREE + 2;
  localparam int NUM_ENTRIES = NUM_TERMS + 2;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int PROD_W      = COEF_W + OPND_W;
  localparam int EXT_W       = (PROD_W > ACC_W) ? PROD_W : ACC_W;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));

  logic        [MEAS_W-1:0] init_measure_q;
  logic signed [CMD_W-1:0]  init_command_q;
  logic        [MEAS_W-1:0] init_setpoint_q;

  logic        [MEAS_W-1:0] meas_hist_q [R_DEGREE];
  logic signed [CMD_W-1:0]  cmd_hist_q  [S_DEGREE];
  logic        [MEAS_W-1:0] ref_hist_q  [T_DEGREE];
  logic signed [OFS_W-1:0]  dc_offset_q;

  logic        [MEAS_W-1:0] sp_q;
  logic        [MEAS_W-1:0] ms_q;
  logic signed [ACC_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     out_valid_q;
  logic signed [CMD_W-1:0]  out_data_q;

  logic signed [COEF_W-1:0] coef_tab [NUM_ENTRIES];
  logic signed [OPND_W-1:0] opnd_tab [NUM_ENTRIES];
  logic        [IDX_W-1:0]  term_sel;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [OPND_W-1:0] opnd_sel;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [EXT_W-1:0]  prod_ext;
  logic                     prod_ovf;
  logic signed [ACC_W-1:0]  prod_sat;

  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_W-1:0]  acc_shr;
  logic                     cmd_ovf;
  logic signed [CMD_W-1:0]  cmd_res;
  logic                     ofs_ovf;
  logic signed [OFS_W-1:0]  ofs_res;

  // init registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_measure_q  <= '0;
      init_command_q  <= '0;
      init_setpoint_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INIT_MEASURE:  init_measure_q  <= cfg_data_i[MEAS_W-1:0];
        CFG_INIT_COMMAND:  init_command_q  <= signed'(cfg_data_i[CMD_W-1:0]);
        CFG_INIT_SETPOINT: init_setpoint_q <= cfg_data_i[MEAS_W-1:0];
        default: ;
      endcase
    end
  end

  // per-term coefficient and operand, coefficients fold to constants
  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_term
    localparam longint CoefVal = term_coef(k, T_DEGREE, R_DEGREE, S_DEGREE, COEF_FRAC_BITS);
    assign coef_tab[k] = COEF_W'(CoefVal);
    if (k < T_DEGREE) begin : g_ref
      assign opnd_tab[k] = {1'b0, ref_hist_q[k], {CMD_FRAC_W{1'b0}}};
    end else if (k < T_DEGREE + R_DEGREE) begin : g_meas
      assign opnd_tab[k] = {1'b0, meas_hist_q[k - T_DEGREE], {CMD_FRAC_W{1'b0}}};
    end else if (k < T_DEGREE + R_DEGREE + S_DEGREE) begin : g_cmd
      assign opnd_tab[k] = OPND_W'(cmd_hist_q[k - T_DEGREE - R_DEGREE]);
    end else if (k == NUM_TERMS - 2) begin : g_ms
      assign opnd_tab[k] = {1'b0, ms_q, {CMD_FRAC_W{1'b0}}};
    end else if (k == NUM_TERMS - 1) begin : g_sp
      assign opnd_tab[k] = {1'b0, sp_q, {CMD_FRAC_W{1'b0}}};
    end else if (k == NUM_TERMS) begin : g_init_ms
      assign opnd_tab[k] = {1'b0, init_measure_q, {CMD_FRAC_W{1'b0}}};
    end else begin : g_init_cmd
      assign opnd_tab[k] = OPND_W'(init_command_q);
    end
  end

  assign term_sel  = ctrl_i.term_idx[IDX_W-1:0];
  assign coef_sel  = coef_tab[term_sel];
  assign opnd_sel  = opnd_tab[term_sel];
  assign prod_full = PROD_W'(coef_sel) * PROD_W'(opnd_sel);
  assign prod_ext  = EXT_W'(prod_full);
  assign prod_ovf  = !((&prod_ext[EXT_W-1:ACC_W-1]) || !(|prod_ext[EXT_W-1:ACC_W-1]));
  assign prod_sat  = prod_ovf ? (prod_ext[EXT_W-1] ? ACC_MIN : ACC_MAX)
                              : prod_ext[ACC_W-1:0];

  // round half up, floor shift, clamp to the command range
  assign acc_rnd = sat_add(acc_q, RND_HALF);
  assign acc_shr = acc_rnd >>> COEF_FRAC_BITS;
  assign cmd_ovf = !((&acc_shr[ACC_W-1:CMD_W-1]) || !(|acc_shr[ACC_W-1:CMD_W-1]));
  assign cmd_res = cmd_ovf ? (acc_shr[ACC_W-1] ? CMD_MIN : CMD_MAX) : acc_shr[CMD_W-1:0];

  assign ofs_ovf = !((&acc_q[ACC_W-1:OFS_W-1]) || !(|acc_q[ACC_W-1:OFS_W-1]));
  assign ofs_res = ofs_ovf ? (acc_q[ACC_W-1] ? OFS_MIN : OFS_MAX) : acc_q[OFS_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sp_q  <= setpoint_i;
      ms_q  <= measure_i;
      acc_q <= ctrl_i.load_reinit ? '0 : ACC_W'(dc_offset_q);
    end else if (ctrl_i.acc_en) begin
      acc_q <= sat_add(acc_q, prod_q);
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_sat;
    end
    if (ctrl_i.commit_sample) begin
      out_data_q <= cmd_res;
    end
  end

  // delay lines and offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < R_DEGREE; i++) meas_hist_q[i] <= '0;
      for (int i = 0; i < S_DEGREE; i++) cmd_hist_q[i] <= '0;
      for (int i = 0; i < T_DEGREE; i++) ref_hist_q[i] <= '0;
      dc_offset_q <= '0;
    end else if (ctrl_i.commit_reinit) begin
      for (int i = 0; i < R_DEGREE; i++) meas_hist_q[i] <= init_measure_q;
      for (int i = 0; i < S_DEGREE; i++) cmd_hist_q[i] <= init_command_q;
      for (int i = 0; i < T_DEGREE; i++) ref_hist_q[i] <= init_setpoint_q;
      dc_offset_q <= ofs_res;
    end else if (ctrl_i.commit_sample) begin
      meas_hist_q[0] <= ms_q;
      cmd_hist_q[0]  <= cmd_res;
      ref_hist_q[0]  <= sp_q;
      for (int i = 1; i < R_DEGREE; i++) meas_hist_q[i] <= meas_hist_q[i-1];
      for (int i = 1; i < S_DEGREE; i++) cmd_hist_q[i] <= cmd_hist_q[i-1];
      for (int i = 1; i < T_DEGREE; i++) ref_hist_q[i] <= ref_hist_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.commit_sample) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign command_o       = out_data_q;

  `RPC_ASSERT(a_out_from_commit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(ctrl_i.commit_sample))
  `RPC_ASSERT(a_no_commit_over_full, clk_i, rst_ni, (out_valid_q && !out_ready_i) |-> !ctrl_i.commit_sample)
  `RPC_ASSERT_CLK(a_reset_clears_out, clk_i, !rst_ni |-> !out_valid_q)

endmodule

`default_nettype wire

// ===== rtl/rst_polynomial_controller.sv =====
// channel   dir  beat fields                         notes
// in_i      in   cmd, setpoint[15:0], measure[15:0]  cmd=1 reinitializes, no result
// out_o     out  command[31:0] (Q16.16, signed)      one beat per sample step
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i     write only, idx 0..2
//
// a sample step goes from accept to result through load, one multiply-accumulate
// per tap (T+R+S+2 taps, 13 by default) through a single 31x33 multiplier,
// drain and finish. a reinitialize beat runs only the two offset terms.
// one beat is worked on at a time; in_i.ready is high only while idle.
// a finished result waits in the output register; the next beat is accepted
// meanwhile and its result stalls in the finish cycle until out_o is taken.
// reset is asynchronous, active low, and clears histories, offset, init registers and out_o.valid.
`default_nettype none

module rst_polynomial_controller import rpc_pkg::*; #(
  parameter int R_DEGREE       = 4,
  parameter int S_DEGREE       = 4,
  parameter int T_DEGREE       = 3,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  rpc_in_if.sink               in_i,
  rpc_out_if.source            out_o
);

  dp_ctrl_t dp_ctrl;
  dp_stat_t dp_stat;

  rpc_ctrl #(
    .R_DEGREE (R_DEGREE),
    .S_DEGREE (S_DEGREE),
    .T_DEGREE (T_DEGREE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .dp_ctrl_o  (dp_ctrl),
    .dp_stat_i  (dp_stat)
  );

  rpc_datapath #(
    .R_DEGREE       (R_DEGREE),
    .S_DEGREE       (S_DEGREE),
    .T_DEGREE       (T_DEGREE),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .setpoint_i  (in_i.setpoint),
    .measure_i   (in_i.measure),
    .ctrl_i      (dp_ctrl),
    .stat_o      (dp_stat),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .command_o   (out_o.command)
  );

endmodule

`default_nettype wire

// ===== test/tb_rst_polynomial_controller.sv =====
`timescale 1ns / 1ps

module tb_rst_polynomial_controller import rpc_pkg::*;;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_BEATS   = 135;

  localparam logic BEAT_SAMPLE = 1'b0;
  localparam logic BEAT_REINIT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  class command_scoreboard;
    localparam int     R_DEG     = 4;
    localparam int     S_DEG     = 4;
    localparam int     T_DEG     = 3;
    localparam int     COEF_FRAC = 28;
    localparam longint DEC_UNIT  = 10000000;
    localparam longint ACC_TOP   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_BOT   = -ACC_TOP - 1;
    localparam longint CMD_TOP   = 2147483647;
    localparam longint CMD_BOT   = -CMD_TOP - 1;
    localparam longint OFS_TOP   = (longint'(1) <<< (OFS_W - 1)) - 1;
    localparam longint OFS_BOT   = -OFS_TOP - 1;

    longint r_coef [0:R_DEG];
    longint s_coef [0:S_DEG];
    longint t_coef [0:T_DEG];

    logic        [MEAS_W-1:0] init_measure;
    logic signed [CMD_W-1:0]  init_command;
    logic        [MEAS_W-1:0] init_setpoint;

    logic        [MEAS_W-1:0] meas_hist [1:R_DEG];
    logic signed [CMD_W-1:0]  cmd_hist  [1:S_DEG];
    logic        [MEAS_W-1:0] ref_hist  [1:T_DEG];
    longint                   offset_acc;

    logic signed [CMD_W-1:0] expected_q [$];
    int unsigned             mismatches;

    function new();
      // polynomial constants in units of 1e-7
      r_coef = '{scale_coef(-1026000), scale_coef(3352000), scale_coef(-3854000),
                 scale_coef(1767000), scale_coef(-238000)};
      s_coef = '{scale_coef(10000000), scale_coef(-30838000), scale_coef(33476000),
                 scale_coef(-14389000), scale_coef(1751000)};
      t_coef = '{scale_coef(8712), scale_coef(-15249), scale_coef(8767), scale_coef(-1493)};
      init_measure  = '0;
      init_command  = '0;
      init_setpoint = '0;
      foreach (meas_hist[j]) meas_hist[j] = '0;
      foreach (cmd_hist[j]) cmd_hist[j] = '0;
      foreach (ref_hist[j]) ref_hist[j] = '0;
      offset_acc = 0;
      mismatches = 0;
    endfunction

    // to Q3.28, round half away from zero
    function longint scale_coef(int tenth_micro);
      longint mag;
      mag = (tenth_micro < 0) ? -longint'(tenth_micro) : longint'(tenth_micro);
      mag = ((mag <<< COEF_FRAC) + DEC_UNIT / 2) / DEC_UNIT;
      return (tenth_micro < 0) ? -mag : mag;
    endfunction

    function longint clip_add(longint a, longint b);
      logic signed [64:0] s;
      s = a + b;
      if (s[64] != s[63]) return s[64] ? ACC_BOT : ACC_TOP;
      return s[63:0];
    endfunction

    function longint clip_mul(longint a, longint b);
      logic signed [127:0] wide_a;
      logic signed [127:0] wide_b;
      logic signed [127:0] p;
      wide_a = a;
      wide_b = b;
      p = wide_a * wide_b;
      if (p[127:63] != {65{p[127]}}) return p[127] ? ACC_BOT : ACC_TOP;
      return p[63:0];
    endfunction

    // integer sample times coefficient, lifted to the command's fraction
    function longint scaled_term(longint coef, longint x);
      return clip_mul(clip_mul(coef, x), 65536);
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_INIT_MEASURE:  init_measure = data[MEAS_W-1:0];
        CFG_INIT_COMMAND:  init_command = data[CMD_W-1:0];
        CFG_INIT_SETPOINT: init_setpoint = data[MEAS_W-1:0];
        default: ;
      endcase
    endfunction

    function void reload_histories();
      longint sum_r;
      longint sum_s;
      longint sum_t;
      longint ofs;
      sum_r = 0;
      sum_s = 0;
      sum_t = 0;
      foreach (r_coef[j]) sum_r += r_coef[j];
      foreach (s_coef[j]) sum_s += s_coef[j];
      foreach (t_coef[j]) sum_t += t_coef[j];
      ofs = clip_add(scaled_term(sum_r - sum_t, init_measure), clip_mul(sum_s, init_command));
      if (ofs > OFS_TOP) ofs = OFS_TOP;
      if (ofs < OFS_BOT) ofs = OFS_BOT;
      offset_acc = ofs;
      foreach (meas_hist[j]) meas_hist[j] = init_measure;
      foreach (cmd_hist[j]) cmd_hist[j] = init_command;
      foreach (ref_hist[j]) ref_hist[j] = init_setpoint;
    endfunction

    function void note_sample(logic kind, logic [MEAS_W-1:0] sp, logic [MEAS_W-1:0] ms);
      longint acc;
      longint q;
      if (kind == BEAT_REINIT) begin
        reload_histories();
        return;
      end
      acc = offset_acc;
      for (int j = 1; j <= T_DEG; j++) acc = clip_add(acc, scaled_term(t_coef[j], ref_hist[j]));
      for (int j = 1; j <= R_DEG; j++) acc = clip_add(acc, scaled_term(-r_coef[j], meas_hist[j]));
      for (int j = 1; j <= S_DEG; j++) acc = clip_add(acc, clip_mul(-s_coef[j], cmd_hist[j]));
      acc = clip_add(acc, scaled_term(-r_coef[0], ms));
      acc = clip_add(acc, scaled_term(t_coef[0], sp));
      acc = clip_add(acc, longint'(1) <<< (COEF_FRAC - 1));
      q = acc >>> COEF_FRAC;
      if (q > CMD_TOP) q = CMD_TOP;
      if (q < CMD_BOT) q = CMD_BOT;
      for (int j = R_DEG; j > 1; j--) meas_hist[j] = meas_hist[j-1];
      for (int j = S_DEG; j > 1; j--) cmd_hist[j] = cmd_hist[j-1];
      for (int j = T_DEG; j > 1; j--) ref_hist[j] = ref_hist[j-1];
      meas_hist[1] = ms;
      cmd_hist[1]  = q[CMD_W-1:0];
      ref_hist[1]  = sp;
      expected_q.push_back(q[CMD_W-1:0]);
    endfunction

    task flag_mismatch(string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_command(logic signed [CMD_W-1:0] got);
      logic signed [CMD_W-1:0] want;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("command beat %0d with no sample pending", got));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) flag_mismatch($sformatf("command got %0d expected %0d", got, want));
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  rpc_in_if  in_if ();
  rpc_out_if out_if ();

  command_scoreboard sb = new();

  int unsigned cycle_count = 0;
  bit          long_hold_req = 1'b0;
  bit          calm_phase = 1'b0;
  int          sp_level;
  int          ms_level;

  rst_polynomial_controller i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_command(out_if.command);
      if (in_if.valid && in_if.ready) sb.note_sample(in_if.cmd, in_if.setpoint, in_if.measure);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : receiver
    out_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (long_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  task automatic send_beat(input logic kind, input logic [MEAS_W-1:0] sp,
                           input logic [MEAS_W-1:0] ms);
    in_if.valid    <= 1'b1;
    in_if.cmd      <= kind;
    in_if.setpoint <= sp;
    in_if.measure  <= ms;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic sender_gap();
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_if.valid    <= 1'b0;
      in_if.cmd      <= 1'($urandom());
      in_if.setpoint <= 16'($urandom());
      in_if.measure  <= 16'($urandom());
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // wait for every pending command, then for any reinit still in flight
  task automatic quiesce();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.apply_register(idx, data);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] meas, input logic [CFG_W-1:0] cmd,
                               input logic [CFG_W-1:0] setp);
    write_register(CFG_INIT_MEASURE, meas);
    write_register(CFG_INIT_COMMAND, cmd);
    write_register(CFG_INIT_SETPOINT, setp);
    // unmapped index must leave all three registers alone
    write_register(CFG_UNUSED_IDX, $urandom());
    cfg_we_i <= 1'b0;
  endtask

  // mostly a measurement that tracks a held setpoint, plus noise and reinits
  task automatic random_beat();
    int unsigned pick;
    int          step;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_beat(BEAT_REINIT, 16'($urandom()), 16'($urandom()));
    end else if (pick < 26) begin
      send_beat(BEAT_SAMPLE, 16'($urandom()), 16'($urandom()));
    end else begin
      if ($urandom_range(0, 29) == 0) sp_level = $urandom_range(0, 65535);
      step = (sp_level - ms_level) / 8 + int'($urandom_range(0, 64)) - 32;
      ms_level = ms_level + step;
      if (ms_level < 0) ms_level = 0;
      if (ms_level > 65535) ms_level = 65535;
      send_beat(BEAT_SAMPLE, sp_level[MEAS_W-1:0], ms_level[MEAS_W-1:0]);
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] cmd_init;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_INIT_MEASURE;
    cfg_data_i     <= '0;
    in_if.valid    <= 1'b0;
    in_if.cmd      <= BEAT_SAMPLE;
    in_if.setpoint <= '0;
    in_if.measure  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at their reset values
    send_beat(BEAT_SAMPLE, 16'h0000, 16'h0000);
    send_beat(BEAT_SAMPLE, 16'hFFFF, 16'h0000);
    send_beat(BEAT_SAMPLE, 16'h0000, 16'hFFFF);
    send_beat(BEAT_SAMPLE, 16'hFFFF, 16'hFFFF);
    send_beat(BEAT_SAMPLE, 16'hAAAA, 16'h5555);
    send_beat(BEAT_REINIT, 16'hFFFF, 16'hFFFF);
    send_beat(BEAT_SAMPLE, 16'h5555, 16'hAAAA);
    send_beat(BEAT_REINIT, 16'h1234, 16'h4321);
    send_beat(BEAT_REINIT, 16'h0000, 16'h0000);
    send_beat(BEAT_SAMPLE, 16'h8000, 16'h7FFF);

    // command history at the top, error pushes it past the limit
    quiesce();
    load_settings(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_beat(BEAT_REINIT, 16'h0000, 16'h0000);
    repeat (3) send_beat(BEAT_SAMPLE, 16'hFFFF, 16'h0000);
    send_beat(BEAT_SAMPLE, 16'h0000, 16'hFFFF);

    quiesce();
    load_settings(32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
    send_beat(BEAT_REINIT, 16'hFFFF, 16'hFFFF);
    repeat (3) send_beat(BEAT_SAMPLE, 16'h0000, 16'hFFFF);
    send_beat(BEAT_SAMPLE, 16'hFFFF, 16'h0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      quiesce();
      case (phase)
        1: load_settings(32'h0000_FFFF, 32'h7FFF_FFFF, 32'h0000_FFFF);
        2: load_settings(32'hFFFF_0000, 32'h8000_0000, 32'hFFFF_0000);
        default: begin
          cmd_init = $signed($urandom()) >>> $urandom_range(0, 16);
          load_settings($urandom(), cmd_init, $urandom());
        end
      endcase
      calm_phase = (phase == PHASES - 1);
      if (phase == 3) long_hold_req = 1'b1;
      // one phase carries the histories over without a reinit
      if (phase != 5) send_beat(BEAT_REINIT, 16'($urandom()), 16'($urandom()));
      sp_level = $urandom_range(0, 65535);
      ms_level = $urandom_range(0, 65535);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // keep offering back to back while the receiver holds off
        if (!(phase == 3 && n < 12)) sender_gap();
        random_beat();
      end
    end

    quiesce();
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rpc_pkg.sv
rtl/rpc_if.sv
rtl/rpc_ctrl.sv
rtl/rpc_datapath.sv
rtl/rst_polynomial_controller.sv
test/tb_rst_polynomial_controller.sv
